// File: sv/srtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared widths, opcodes and the structures used between controller and
// datapath of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int SRTF_MAX_PROCESSES_DEF = 16;

    localparam int PID_W   = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic accept;
        logic load_exec;
        logic scan_run;
        logic update_exec;
        logic emit;
    } srtf_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } srtf_status_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
    } srtf_entry_t;

    typedef struct packed {
        logic              ran;
        logic [PID_W-1:0]  run_pid;
        logic [TIME_W-1:0] tick_time;
        logic              new_segment;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
        logic              load_error;
    } srtf_result_t;

endpackage
`default_nettype wire

// File: sv/srtf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF scheduler controller
// Sequences each request through load or scan and update, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module srtf_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    input  wire                    s_opcode,
    output logic                   s_ready,
    input  srtf_pkg::srtf_status_t status,
    output srtf_pkg::srtf_cmd_t    cmd
);
    import srtf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_opcode == OP_TICK) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_exec = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update_exec = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_scan_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_run |-> (state_reg == ST_SCAN))
        else $error("Scan command outside the scan state.");

    a_update_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update_exec |-> $past(state_reg) == ST_SCAN)
        else $error("Update did not follow a scan.");

    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_SCAN || state_reg == ST_LOAD))
        else $error("Accepted request did not start work.");

endmodule
`default_nettype wire

// File: sv/srtf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF scheduler datapath
// Process table memory, sequential minimum-remaining scan, entry update,
// timing statistics and the result output register.
// ----------------------------------------------------------------------------
module srtf_datapath #(
    parameter int MAX_PROCESSES = srtf_pkg::SRTF_MAX_PROCESSES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  srtf_pkg::srtf_cmd_t                cmd,
    output srtf_pkg::srtf_status_t             status,
    input  wire [srtf_pkg::PID_W-1:0]          s_process_id,
    input  wire [srtf_pkg::ARR_W-1:0]          s_arrival_time,
    input  wire [srtf_pkg::BURST_W-1:0]        s_burst_length,
    input  wire                                m_ready,
    output logic                               m_valid,
    output logic                               m_ran,
    output logic [srtf_pkg::PID_W-1:0]         m_run_pid,
    output logic [srtf_pkg::TIME_W-1:0]        m_tick_time,
    output logic                               m_new_segment,
    output logic                               m_finished,
    output logic [srtf_pkg::TIME_W-1:0]        m_turnaround,
    output logic [srtf_pkg::TIME_W-1:0]        m_waiting,
    output logic                               m_all_done,
    output logic                               m_load_error
);
    import srtf_pkg::*;

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    srtf_entry_t        mem [MAX_PROCESSES];
    srtf_entry_t        rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    srtf_entry_t        wr_data;
    logic [IDX_W-1:0]   rd_addr;

    logic [CNT_W-1:0]         entry_count_reg;
    logic [CNT_W-1:0]         done_count_reg;
    logic [MAX_PROCESSES-1:0] done_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [PID_W-1:0]         last_pid_reg;
    logic                     last_valid_reg;

    logic [PID_W-1:0]   in_pid_reg;
    logic [ARR_W-1:0]   in_arr_reg;
    logic [BURST_W-1:0] in_burst_reg;

    logic [CNT_W-1:0]   scan_addr_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    srtf_entry_t        best_reg;
    logic               found_reg;

    srtf_result_t       res_reg;
    srtf_result_t       res_next;
    srtf_result_t       out_reg;
    logic               m_valid_reg;

    logic               full;
    logic               more_entries;
    logic               issue;
    logic               eligible;
    logic [TIME_W-1:0]  rd_arr_ext;
    logic [TIME_W-1:0]  best_arr_ext;
    logic [TIME_W-1:0]  best_burst_ext;
    logic [TIME_W-1:0]  time_next;
    logic [BURST_W-1:0] rem_next;
    logic               fin;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  wt;
    logic               new_seg;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   done_count_inc;

    assign full         = (entry_count_reg == CNT_W'(MAX_PROCESSES));
    assign more_entries = (scan_addr_reg < entry_count_reg);
    assign issue        = cmd.scan_run && more_entries;
    assign rd_addr      = scan_addr_reg[IDX_W-1:0];

    assign rd_arr_ext     = {{(TIME_W-ARR_W){1'b0}}, rd_data_reg.arrival};
    assign best_arr_ext   = {{(TIME_W-ARR_W){1'b0}}, best_reg.arrival};
    assign best_burst_ext = {{(TIME_W-BURST_W){1'b0}}, best_reg.burst};

    assign eligible = rd_valid_reg && !done_reg[rd_idx_reg] && (rd_arr_ext <= time_reg)
                      && (!found_reg || (rd_data_reg.remaining < best_reg.remaining));

    assign time_next = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 1'b1;
    assign rem_next  = (best_reg.remaining == '0) ? '0 : best_reg.remaining - 1'b1;
    assign fin       = found_reg && (rem_next == '0);
    assign tat       = time_next - best_arr_ext;
    assign wt        = (tat >= best_burst_ext) ? tat - best_burst_ext : '0;
    assign new_seg   = !last_valid_reg || (last_pid_reg != best_reg.pid);

    assign count_inc      = entry_count_reg + 1'b1;
    assign done_count_inc = done_count_reg + 1'b1;

    assign status.scan_done = !more_entries && !rd_valid_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = entry_count_reg[IDX_W-1:0];
        wr_data = '{pid: in_pid_reg, arrival: in_arr_reg, burst: in_burst_reg,
                    remaining: in_burst_reg};
        if (cmd.load_exec && !full) begin
            wr_en = 1'b1;
        end else if (cmd.update_exec && found_reg) begin
            wr_en             = 1'b1;
            wr_addr           = best_idx_reg;
            wr_data           = best_reg;
            wr_data.remaining = rem_next;
        end
    end

    always_comb begin
        res_next           = '0;
        res_next.tick_time = time_reg;
        if (cmd.load_exec) begin
            res_next.load_error = full;
            res_next.all_done   = (done_count_reg == (full ? entry_count_reg : count_inc));
        end else begin
            res_next.ran         = found_reg;
            res_next.run_pid     = found_reg ? best_reg.pid : '0;
            res_next.new_segment = found_reg && new_seg;
            res_next.finished    = fin;
            res_next.turnaround  = fin ? tat : '0;
            res_next.waiting     = fin ? wt : '0;
            res_next.all_done    = ((fin ? done_count_inc : done_count_reg) == entry_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_pid_reg   <= s_process_id;
            in_arr_reg   <= s_arrival_time;
            in_burst_reg <= s_burst_length;
        end
        rd_idx_reg <= rd_addr;
        if (eligible) begin
            best_idx_reg <= rd_idx_reg;
            best_reg     <= rd_data_reg;
        end
        if (cmd.load_exec || cmd.update_exec) begin
            res_reg <= res_next;
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            done_count_reg  <= '0;
            done_reg        <= '0;
            time_reg        <= '0;
            last_pid_reg    <= '0;
            last_valid_reg  <= 1'b0;
            scan_addr_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (cmd.accept) begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
            end else if (issue) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (eligible) begin
                found_reg <= 1'b1;
            end
            if (cmd.load_exec && !full) begin
                entry_count_reg                       <= count_inc;
                done_reg[entry_count_reg[IDX_W-1:0]] <= 1'b0;
            end
            if (cmd.update_exec) begin
                time_reg <= time_next;
                if (found_reg) begin
                    last_pid_reg   <= best_reg.pid;
                    last_valid_reg <= 1'b1;
                end
                if (fin) begin
                    done_reg[best_idx_reg] <= 1'b1;
                    done_count_reg         <= done_count_inc;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ran         = out_reg.ran;
    assign m_run_pid     = out_reg.run_pid;
    assign m_tick_time   = out_reg.tick_time;
    assign m_new_segment = out_reg.new_segment;
    assign m_finished    = out_reg.finished;
    assign m_turnaround  = out_reg.turnaround;
    assign m_waiting     = out_reg.waiting;
    assign m_all_done    = out_reg.all_done;
    assign m_load_error  = out_reg.load_error;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_W'(MAX_PROCESSES))
        else $error("Entry count exceeds the table depth.");

    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_count_reg <= entry_count_reg)
        else $error("More entries done than loaded.");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.ran) |->
        (out_reg.run_pid == '0 && !out_reg.new_segment && !out_reg.finished))
        else $error("Idle result carries run fields.");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("Result overwrote a pending output.");

endmodule
`default_nettype wire

// File: sv/srtf_process_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF process scheduler unit
// Preemptive shortest-remaining-time-first scheduler over a process table.
// A tick request scans the loaded entries, then updates the chosen one; a load
// request writes a table entry unless the table is full. An untaken result
// stalls the next request.
// Synchronous active-low reset clears counts, time and done flags at once.
// ----------------------------------------------------------------------------
module srtf_process_scheduler_unit #(
    parameter int MAX_PROCESSES = srtf_pkg::SRTF_MAX_PROCESSES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_opcode,
    input  wire [srtf_pkg::PID_W-1:0]    s_process_id,
    input  wire [srtf_pkg::ARR_W-1:0]    s_arrival_time,
    input  wire [srtf_pkg::BURST_W-1:0]  s_burst_length,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_ran,
    output logic [srtf_pkg::PID_W-1:0]   m_run_pid,
    output logic [srtf_pkg::TIME_W-1:0]  m_tick_time,
    output logic                         m_new_segment,
    output logic                         m_finished,
    output logic [srtf_pkg::TIME_W-1:0]  m_turnaround,
    output logic [srtf_pkg::TIME_W-1:0]  m_waiting,
    output logic                         m_all_done,
    output logic                         m_load_error
);
    import srtf_pkg::*;

    srtf_cmd_t    cmd;
    srtf_status_t status;

    srtf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srtf_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_process_id   (s_process_id),
        .s_arrival_time (s_arrival_time),
        .s_burst_length (s_burst_length),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_ran          (m_ran),
        .m_run_pid      (m_run_pid),
        .m_tick_time    (m_tick_time),
        .m_new_segment  (m_new_segment),
        .m_finished     (m_finished),
        .m_turnaround   (m_turnaround),
        .m_waiting      (m_waiting),
        .m_all_done     (m_all_done),
        .m_load_error   (m_load_error)
    );

endmodule
`default_nettype wire

// File: bench/tb_srtf_process_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF process scheduler unit testbench
// Drives load and tick requests over the valid/ready input channel and
// checks every result against a shadow scheduler kept in a scoreboard
// class. It covers directed corner cases and a random fill of the process
// table, followed by a long run of ticks mixed with loads into a full table.
// Sender and receiver idle at random, and the result side stalls for a long
// stretch once.
// ----------------------------------------------------------------------------
module tb_srtf_process_scheduler_unit;

    import srtf_pkg::*;

    localparam int SLOT_COUNT  = SRTF_MAX_PROCESSES_DEF;
    localparam int ITEM_TARGET = 1700;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 400;

    class sched_book;
        logic [PID_W-1:0]   slot_pid     [SLOT_COUNT];
        logic [ARR_W-1:0]   slot_arrival [SLOT_COUNT];
        logic [BURST_W-1:0] slot_burst   [SLOT_COUNT];
        logic [BURST_W-1:0] slot_left    [SLOT_COUNT];
        bit                 slot_done    [SLOT_COUNT];
        int unsigned        slots_used;
        int unsigned        slots_done;
        logic [TIME_W-1:0]  clock_now;
        logic [PID_W-1:0]   prev_pid;
        bit                 prev_valid;
        srtf_result_t       outcome_q[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        loads, full_loads, ticks, runs, completions, segments;

        function new();
            slots_used  = 0;
            slots_done  = 0;
            clock_now   = '0;
            prev_pid    = '0;
            prev_valid  = 1'b0;
            mismatches  = 0;
            checked     = 0;
            loads       = 0;
            full_loads  = 0;
            ticks       = 0;
            runs        = 0;
            completions = 0;
            segments    = 0;
            foreach (slot_done[i]) slot_done[i] = 1'b0;
        endfunction

        function int unsigned outstanding();
            return outcome_q.size();
        endfunction

        function void note_request(logic op, logic [PID_W-1:0] pid,
                                   logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst);
            srtf_result_t      r;
            int                pick;
            logic [BURST_W:0]  pick_left;
            logic [TIME_W-1:0] spent;
            r = '0;
            r.tick_time = clock_now;
            if (op == OP_LOAD) begin
                loads++;
                if (slots_used < SLOT_COUNT) begin
                    slot_pid[slots_used]     = pid;
                    slot_arrival[slots_used] = arr;
                    slot_burst[slots_used]   = burst;
                    slot_left[slots_used]    = burst;
                    slot_done[slots_used]    = 1'b0;
                    slots_used++;
                end else begin
                    r.load_error = 1'b1;
                    full_loads++;
                end
            end else begin
                ticks++;
                pick = -1;
                pick_left = '1;
                for (int i = 0; i < slots_used; i++) begin
                    if (!slot_done[i] && slot_arrival[i] <= clock_now &&
                        {1'b0, slot_left[i]} < pick_left) begin
                        pick_left = {1'b0, slot_left[i]};
                        pick = i;
                    end
                end
                if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
                if (pick >= 0) begin
                    runs++;
                    r.ran = 1'b1;
                    r.run_pid = slot_pid[pick];
                    r.new_segment = !prev_valid || prev_pid != slot_pid[pick];
                    if (r.new_segment) segments++;
                    prev_pid = slot_pid[pick];
                    prev_valid = 1'b1;
                    if (slot_left[pick] != 0) slot_left[pick] = slot_left[pick] - 1'b1;
                    if (slot_left[pick] == 0) begin
                        completions++;
                        r.finished = 1'b1;
                        slot_done[pick] = 1'b1;
                        slots_done++;
                        spent = clock_now - TIME_W'(slot_arrival[pick]);
                        r.turnaround = spent;
                        r.waiting = (spent >= TIME_W'(slot_burst[pick])) ?
                                    spent - TIME_W'(slot_burst[pick]) : '0;
                    end
                end
            end
            r.all_done = (slots_done == slots_used);
            outcome_q.insert(outcome_q.size(), r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("Mismatch on result %0d: %s", checked, what);
        endtask

        task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_outcome(srtf_result_t got);
            srtf_result_t want;
            checked++;
            if (outcome_q.size() == 0) begin
                report_mismatch("result arrived with no request pending");
            end else begin
                want = outcome_q.pop_front();
                compare_field("ran",         TIME_W'(got.ran),         TIME_W'(want.ran));
                compare_field("run_pid",     TIME_W'(got.run_pid),     TIME_W'(want.run_pid));
                compare_field("tick_time",   got.tick_time,            want.tick_time);
                compare_field("new_segment", TIME_W'(got.new_segment),
                              TIME_W'(want.new_segment));
                compare_field("finished",    TIME_W'(got.finished),    TIME_W'(want.finished));
                compare_field("turnaround",  got.turnaround,           want.turnaround);
                compare_field("waiting",     got.waiting,              want.waiting);
                compare_field("all_done",    TIME_W'(got.all_done),    TIME_W'(want.all_done));
                compare_field("load_error",  TIME_W'(got.load_error),
                              TIME_W'(want.load_error));
            end
        endtask
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_opcode       = 1'b0;
    logic [PID_W-1:0]    s_process_id   = '0;
    logic [ARR_W-1:0]    s_arrival_time = '0;
    logic [BURST_W-1:0]  s_burst_length = '0;
    logic                m_ready        = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic                m_ran;
    logic [PID_W-1:0]    m_run_pid;
    logic [TIME_W-1:0]   m_tick_time;
    logic                m_new_segment;
    logic                m_finished;
    logic [TIME_W-1:0]   m_turnaround;
    logic [TIME_W-1:0]   m_waiting;
    logic                m_all_done;
    logic                m_load_error;

    sched_book    board;
    int unsigned  items_sent    = 0;
    int unsigned  results_seen  = 0;
    int unsigned  send_idle_pct = 13;
    int unsigned  recv_idle_pct = 88;
    int unsigned  hold_left     = 0;
    bit           held_once     = 1'b0;
    int unsigned  quiet_cycles  = 0;
    srtf_result_t observed;

    srtf_process_scheduler_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_process_id   (s_process_id),
        .s_arrival_time (s_arrival_time),
        .s_burst_length (s_burst_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ran          (m_ran),
        .m_run_pid      (m_run_pid),
        .m_tick_time    (m_tick_time),
        .m_new_segment  (m_new_segment),
        .m_finished     (m_finished),
        .m_turnaround   (m_turnaround),
        .m_waiting      (m_waiting),
        .m_all_done     (m_all_done),
        .m_load_error   (m_load_error)
    );

    always #6 aclk = ~aclk;

    task automatic drive_request(input logic op, input logic [PID_W-1:0] pid,
                                 input logic [ARR_W-1:0] arr,
                                 input logic [BURST_W-1:0] burst);
        if (items_sent == ITEM_TARGET / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 13;
        end else if (items_sent == 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_process_id   <= pid;
        s_arrival_time <= arr;
        s_burst_length <= burst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(op, pid, arr, burst);
        items_sent++;
    endtask

    task automatic run_ticks(input int unsigned count);
        repeat (count) drive_request(OP_TICK, PID_W'($urandom), ARR_W'($urandom),
                                     BURST_W'($urandom_range(1, 65535)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.outstanding() != 0);
    endtask

    task automatic load_random_entry();
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        if ($urandom_range(0, 4) == 0)
            arr = ARR_W'($urandom_range(0, int'(board.clock_now) + 100));
        else
            arr = ARR_W'(int'(board.clock_now) + $urandom_range(0, 40));
        if ($urandom_range(0, 5) == 0)
            burst = BURST_W'($urandom_range(60, 400));
        else
            burst = BURST_W'($urandom_range(1, 60));
        drive_request(OP_LOAD, PID_W'($urandom), arr, burst);
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty table, preemption, a zero burst, out-of-order
        // arrival, a tie on remaining burst and ticks after everything is done.
        run_ticks(1);
        drive_request(OP_LOAD, 8'h00, 16'd0, 16'd3);
        drive_request(OP_LOAD, 8'hFF, 16'd1, 16'd1);
        drive_request(OP_LOAD, 8'h5A, 16'd3, 16'd0);
        drive_request(OP_LOAD, 8'h33, 16'd2, 16'd2);
        run_ticks(9);
        drive_request(OP_LOAD, 8'h11, ARR_W'(board.clock_now), 16'd2);
        drive_request(OP_LOAD, 8'h10, ARR_W'(board.clock_now), 16'd2);
        run_ticks(5);
        drain_results();

        // Random fill of the table with mostly well-ordered arrivals; the
        // last slot holds an entry that never becomes eligible.
        while (board.slots_used < SLOT_COUNT - 1) begin
            run_ticks($urandom_range(0, 60));
            load_random_entry();
        end
        drive_request(OP_LOAD, PID_W'($urandom), 16'hFFFF, 16'hFFFF);
        drain_results();

        // Ticks mixed with loads into the full table.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 15)
                drive_request(OP_LOAD, PID_W'($urandom), ARR_W'($urandom),
                              BURST_W'($urandom_range(1, 65535)));
            else
                run_ticks(1);
        end
        drain_results();
        repeat (40) @(posedge aclk);

        $display("Ran %0d loads (%0d into a full table) and %0d ticks.",
                 board.loads, board.full_loads, board.ticks);
        $display("Processes ran in %0d ticks with %0d segment starts and %0d completions.",
                 board.runs, board.segments, board.completions);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed.ran         = m_ran;
            observed.run_pid     = m_run_pid;
            observed.tick_time   = m_tick_time;
            observed.new_segment = m_new_segment;
            observed.finished    = m_finished;
            observed.turnaround  = m_turnaround;
            observed.waiting     = m_waiting;
            observed.all_done    = m_all_done;
            observed.load_error  = m_load_error;
            board.check_outcome(observed);
            results_seen++;
        end
        if (!held_once && results_seen == HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Timeout: no request or result moved for %0d cycles",
                             QUIET_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

endmodule
